// ----- rtl/cstrip_pkg.sv -----
// Package for the comment stripper: beat types, mode codes and the
// per-byte resolve function. No dependencies.
`default_nettype none

package cstrip_pkg;

  localparam logic [7:0] CHR_NL    = 8'h0A;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_BSL   = 8'h5C;
  localparam logic [7:0] CHR_DQ    = 8'h22;
  localparam logic [7:0] CHR_SQ    = 8'h27;
  localparam logic [7:0] CHR_SP    = 8'h20;

  // Result queue depth; power of two, at least 2.
  localparam int unsigned OBUF_DEPTH = 4;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_BLOCK  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_STRING = 3'd3,
    MODE_CHAR   = 3'd4
  } mode_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_out;
  } out_beat_t;

  // Up to two result beats per accepted input beat.
  typedef struct packed {
    logic [1:0] n;
    out_beat_t  b0;
    out_beat_t  b1;
  } push_t;

  typedef struct packed {
    logic [7:0] ch;
    mode_e      mode;
    logic       pb;
    logic       pair;
  } res_t;

  function automatic res_t resolve(mode_e m, logic pb, logic [7:0] b,
                                   logic la_ok, logic [7:0] la);
    res_t r;
    logic isbs;
    isbs   = (b == CHR_BSL);
    r.ch   = b;
    r.mode = m;
    r.pb   = isbs;
    r.pair = 1'b0;
    if (b == CHR_NL) begin
      if (m == MODE_LINE) r.mode = MODE_NORMAL;
      r.pb = 1'b0;
    end else begin
      case (m)
        MODE_BLOCK: begin
          r.ch = CHR_SP;
          if (la_ok && b == CHR_COLON && la == CHR_BSL) begin
            r.mode = MODE_NORMAL;
            r.pair = 1'b1;
            r.pb   = 1'b1;
          end
        end
        MODE_LINE: begin
          r.ch = CHR_SP;
        end
        MODE_STRING: begin
          if (b == CHR_DQ && !pb) r.mode = MODE_NORMAL;
        end
        MODE_CHAR: begin
          if (b == CHR_SQ && !pb) r.mode = MODE_NORMAL;
        end
        default: begin
          r.mode = MODE_NORMAL;
          if (la_ok && isbs && la == CHR_COLON) begin
            r.ch   = CHR_SP;
            r.mode = MODE_BLOCK;
            r.pair = 1'b1;
            r.pb   = 1'b0;
          end else if (isbs) begin
            r.ch   = CHR_SP;
            r.mode = MODE_LINE;
          end else if (b == CHR_DQ) begin
            r.mode = MODE_STRING;
          end else if (b == CHR_SQ) begin
            r.mode = MODE_CHAR;
          end
        end
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cstrip_obuf.sv -----
// Result queue of the comment stripper: takes up to two beats a cycle,
// gives one a cycle while the output is not stalled. Depends on cstrip_pkg.
`default_nettype none

module cstrip_obuf #(
  parameter int unsigned DEPTH = cstrip_pkg::OBUF_DEPTH
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire cstrip_pkg::push_t push_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output cstrip_pkg::out_beat_t  out_data_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cstrip_pkg::out_beat_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room_o      = (count_q <= CntW'(DEPTH - 2));
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.n);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_i.n) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_ptr_q] <= push_i.b0;
    if (push_i.n == 2'd2) mem_q[wr_ptr_q + PtrW'(1)] <= push_i.b1;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("result queue count beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> (count_q <= CntW'(DEPTH - 2)))
    else $error("push into result queue without room");

endmodule

`default_nettype wire

// ----- rtl/comment_stripper.sv -----
// Top level of the comment stripper: lookahead state and resolve logic,
// feeding the result queue. Depends on cstrip_pkg and cstrip_obuf.
//
// One source byte is taken per clock while the queue has room. Each byte is
// held until the next one arrives so that two-byte markers can be seen; its
// result goes into a small result queue in the same cycle as that next byte
// is taken (the final byte's result goes in together with it).
// A marker pair gives two result beats at once and the final byte may too;
// the queue (OBUF_DEPTH entries) absorbs that, and input is stalled only
// when fewer than two free entries remain, which on a free-running output
// does not happen. Sustained rate: one byte per cycle while the output is not stalled.
`default_nettype none

module comment_stripper #(
  parameter int unsigned OBUF_DEPTH = cstrip_pkg::OBUF_DEPTH
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire cstrip_pkg::in_beat_t in_data_i,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output cstrip_pkg::out_beat_t     out_data_o
);

  cstrip_pkg::mode_e mode_q, mode_d;
  logic              held_valid_q, held_valid_d;
  logic [7:0]        held_byte_q, held_byte_d;
  logic              prev_bsl_q, prev_bsl_d;

  logic              room;
  logic              in_acc;
  cstrip_pkg::push_t push;
  cstrip_pkg::res_t  r_held, r_last;
  cstrip_pkg::mode_e mode_mid;
  logic              pb_mid;

  assign in_stall_o = !room;
  assign in_acc     = in_valid_i && room;

  always_comb begin
    r_held   = cstrip_pkg::resolve(mode_q, prev_bsl_q, held_byte_q, 1'b1,
                                   in_data_i.char_in);
    mode_mid = held_valid_q ? r_held.mode : mode_q;
    pb_mid   = held_valid_q ? r_held.pb : prev_bsl_q;
    r_last   = cstrip_pkg::resolve(mode_mid, pb_mid, in_data_i.char_in,
                                   1'b0, 8'h00);

    mode_d       = mode_q;
    held_valid_d = held_valid_q;
    held_byte_d  = held_byte_q;
    prev_bsl_d   = prev_bsl_q;
    push         = '0;

    if (in_acc) begin
      if (held_valid_q) begin
        push.n           = 2'd1;
        push.b0.char_out = r_held.ch;
        push.b0.last_out = 1'b0;
      end
      if (held_valid_q && r_held.pair) begin
        push.n           = 2'd2;
        push.b1.char_out = cstrip_pkg::CHR_SP;
        push.b1.last_out = in_data_i.last;
        held_valid_d     = 1'b0;
        held_byte_d      = 8'h00;
        mode_d           = mode_mid;
        prev_bsl_d       = pb_mid;
      end else if (in_data_i.last) begin
        if (held_valid_q) begin
          push.n           = 2'd2;
          push.b1.char_out = r_last.ch;
          push.b1.last_out = 1'b1;
        end else begin
          push.n           = 2'd1;
          push.b0.char_out = r_last.ch;
          push.b0.last_out = 1'b1;
        end
        held_valid_d = 1'b0;
        held_byte_d  = 8'h00;
        mode_d       = cstrip_pkg::MODE_NORMAL;
        prev_bsl_d   = 1'b0;
      end else begin
        held_valid_d = 1'b1;
        held_byte_d  = in_data_i.char_in;
        mode_d       = mode_mid;
        prev_bsl_d   = pb_mid;
      end
      // final beat after a pair also returns to the start state
      if (in_data_i.last) begin
        mode_d     = cstrip_pkg::MODE_NORMAL;
        prev_bsl_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= cstrip_pkg::MODE_NORMAL;
      held_valid_q <= 1'b0;
      held_byte_q  <= 8'h00;
      prev_bsl_q   <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      held_valid_q <= held_valid_d;
      held_byte_q  <= held_byte_d;
      prev_bsl_q   <= prev_bsl_d;
    end
  end

  cstrip_obuf #(
    .DEPTH(OBUF_DEPTH)
  ) u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  a_two_need_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n == 2'd2) |-> held_valid_q)
    else $error("two results without a held byte");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.last) |=>
      (!held_valid_q && mode_q == cstrip_pkg::MODE_NORMAL && !prev_bsl_q))
    else $error("state not cleared after final byte");

endmodule

`default_nettype wire

// ----- tb/comment_stripper_test.sv -----
// Self-checking testbench for comment_stripper: a directed table of source
// bytes, then random streams, checked against a model or the table's fixed values.
// Depends on cstrip_pkg and comment_stripper.
`timescale 1ns / 100ps

module comment_stripper_test;

  localparam int RAND_ITEMS  = 1700;
  localparam int CALM_FROM   = 1450;
  localparam int DRAIN_AT    = 700;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    cstrip_pkg::in_beat_t  beat;
    bit                    typed;
    int                    n;
    cstrip_pkg::out_beat_t e0;
    cstrip_pkg::out_beat_t e1;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cstrip_pkg::in_beat_t  in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  cstrip_pkg::out_beat_t out_data;

  // model of the stripper
  cstrip_pkg::mode_e strip_mode;
  logic              hold_v;
  logic [7:0]        hold_b;
  logic              bsl_before;

  cstrip_pkg::out_beat_t strip_q[$];
  int                    errors = 0;
  int                    cycles = 0;
  int                    stall_left = 0;
  bit                    calm = 1'b0;

  always #10 clk = ~clk;

  comment_stripper u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  function automatic void clear_strip();
    strip_mode = cstrip_pkg::MODE_NORMAL;
    hold_v     = 1'b0;
    hold_b     = 8'h00;
    bsl_before = 1'b0;
  endfunction

  function automatic logic [7:0] blank(input logic [7:0] b, input logic la_ok,
                                       input logic [7:0] la, output logic paired);
    logic is_bsl;
    is_bsl = (b == cstrip_pkg::CHR_BSL);
    paired = 1'b0;
    if (b == cstrip_pkg::CHR_NL) begin
      if (strip_mode == cstrip_pkg::MODE_LINE) strip_mode = cstrip_pkg::MODE_NORMAL;
      bsl_before = 1'b0;
      return b;
    end
    case (strip_mode)
      cstrip_pkg::MODE_BLOCK: begin
        if (la_ok && b == cstrip_pkg::CHR_COLON && la == cstrip_pkg::CHR_BSL) begin
          strip_mode = cstrip_pkg::MODE_NORMAL;
          paired     = 1'b1;
          bsl_before = 1'b1;
        end else begin
          bsl_before = is_bsl;
        end
        return cstrip_pkg::CHR_SP;
      end
      cstrip_pkg::MODE_LINE: begin
        bsl_before = is_bsl;
        return cstrip_pkg::CHR_SP;
      end
      cstrip_pkg::MODE_STRING: begin
        if (b == cstrip_pkg::CHR_DQ && !bsl_before) strip_mode = cstrip_pkg::MODE_NORMAL;
        bsl_before = is_bsl;
        return b;
      end
      cstrip_pkg::MODE_CHAR: begin
        if (b == cstrip_pkg::CHR_SQ && !bsl_before) strip_mode = cstrip_pkg::MODE_NORMAL;
        bsl_before = is_bsl;
        return b;
      end
      default: begin
        if (la_ok && is_bsl && la == cstrip_pkg::CHR_COLON) begin
          strip_mode = cstrip_pkg::MODE_BLOCK;
          paired     = 1'b1;
          bsl_before = 1'b0;
          return cstrip_pkg::CHR_SP;
        end
        if (is_bsl) begin
          strip_mode = cstrip_pkg::MODE_LINE;
          bsl_before = 1'b1;
          return cstrip_pkg::CHR_SP;
        end
        if (b == cstrip_pkg::CHR_DQ) strip_mode = cstrip_pkg::MODE_STRING;
        else if (b == cstrip_pkg::CHR_SQ) strip_mode = cstrip_pkg::MODE_CHAR;
        else strip_mode = cstrip_pkg::MODE_NORMAL;
        bsl_before = 1'b0;
        return b;
      end
    endcase
  endfunction

  function automatic int strip_beat(input cstrip_pkg::in_beat_t beat,
                                    output cstrip_pkg::out_beat_t r0,
                                    output cstrip_pkg::out_beat_t r1);
    int         n;
    logic       paired;
    logic [7:0] ch;
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (hold_v) begin
      ch = blank(hold_b, 1'b1, beat.char_in, paired);
      r0 = '{char_out: ch, last_out: 1'b0};
      n  = 1;
      if (paired) begin
        r1     = '{char_out: cstrip_pkg::CHR_SP, last_out: beat.last};
        hold_v = 1'b0;
        hold_b = 8'h00;
        if (beat.last) clear_strip();
        return 2;
      end
    end
    hold_b = beat.char_in;
    hold_v = 1'b1;
    if (beat.last) begin
      ch = blank(hold_b, 1'b0, 8'h00, paired);
      if (n == 0) r0 = '{char_out: ch, last_out: 1'b1};
      else r1 = '{char_out: ch, last_out: 1'b1};
      n++;
      clear_strip();
    end
    return n;
  endfunction

  function automatic dir_row_t mk_row(input logic [7:0] c, input logic last,
                                      input bit typed, input int n,
                                      input cstrip_pkg::out_beat_t e0,
                                      input cstrip_pkg::out_beat_t e1);
    dir_row_t r;
    r.beat  = '{char_in: c, last: last};
    r.typed = typed;
    r.n     = n;
    r.e0    = e0;
    r.e1    = e1;
    return r;
  endfunction

  // biased towards marker, quote and newline bytes so every mode gets exercised
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return cstrip_pkg::CHR_NL;
    if (r < 22) return cstrip_pkg::CHR_BSL;
    if (r < 34) return cstrip_pkg::CHR_COLON;
    if (r < 44) return cstrip_pkg::CHR_DQ;
    if (r < 54) return cstrip_pkg::CHR_SQ;
    if (r < 62) return cstrip_pkg::CHR_SP;
    if (r < 74) return 8'($urandom_range(0, 255));
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch %s: got %h, expected %h (cycle %0d)", what, got, want, cycles);
  endtask

  task automatic send_beat(input dir_row_t row);
    cstrip_pkg::out_beat_t r0, r1;
    int                    n;
    int                    gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = row.beat;
    do @(posedge clk); while (in_stall);
    n = strip_beat(row.beat, r0, r1);
    if (row.typed) begin
      n  = row.n;
      r0 = row.e0;
      r1 = row.e1;
    end
    if (n > 0) strip_q = {strip_q, r0};
    if (n > 1) strip_q = {strip_q, r1};
  endtask

  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cstrip_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (strip_q.size() == 0) begin
        report_mismatch("unexpected beat", out_data.char_out, 8'h00);
      end else begin
        want = strip_q.pop_front();
        if (out_data.char_out !== want.char_out)
          report_mismatch("char_out", out_data.char_out, want.char_out);
        if (out_data.last_out !== want.last_out)
          report_mismatch("last_out", 8'(out_data.last_out), 8'(want.last_out));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("comment_stripper_test: FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    int       sent;
    int       flen;
    clear_strip();
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    rows = {rows, mk_row(8'h00, 1'b0, 1, 0, '0, '0)};
    rows = {rows, mk_row(8'hFF, 1'b0, 1, 1, cstrip_pkg::out_beat_t'{8'h00, 1'b0}, '0)};
    rows = {rows, mk_row(cstrip_pkg::CHR_BSL, 1'b0, 0, 0, '0, '0)};
    // opening marker: both bytes blanked at once
    rows = {rows, mk_row(cstrip_pkg::CHR_COLON, 1'b0, 1, 2,
                         cstrip_pkg::out_beat_t'{cstrip_pkg::CHR_SP, 1'b0},
                         cstrip_pkg::out_beat_t'{cstrip_pkg::CHR_SP, 1'b0})};
    rows = {rows, mk_row(8'h61, 1'b0, 1, 0, '0, '0)};
    rows = {rows, mk_row(cstrip_pkg::CHR_COLON, 1'b0, 1, 1,
                         cstrip_pkg::out_beat_t'{cstrip_pkg::CHR_SP, 1'b0}, '0)};
    rows = {rows, mk_row(cstrip_pkg::CHR_BSL, 1'b0, 1, 2,
                         cstrip_pkg::out_beat_t'{cstrip_pkg::CHR_SP, 1'b0},
                         cstrip_pkg::out_beat_t'{cstrip_pkg::CHR_SP, 1'b0})};
    // string with escaped quote, spanning a line; quote at line start closes
    rows = {rows, mk_row(cstrip_pkg::CHR_DQ, 1'b0, 0, 0, '0, '0)};
    rows = {rows, mk_row(cstrip_pkg::CHR_BSL, 1'b0, 0, 0, '0, '0)};
    rows = {rows, mk_row(cstrip_pkg::CHR_DQ, 1'b0, 0, 0, '0, '0)};
    rows = {rows, mk_row(cstrip_pkg::CHR_NL, 1'b0, 0, 0, '0, '0)};
    rows = {rows, mk_row(cstrip_pkg::CHR_DQ, 1'b0, 0, 0, '0, '0)};
    // character literal with a backslash, spanning a line; quote at line start closes
    rows = {rows, mk_row(cstrip_pkg::CHR_SQ, 1'b0, 0, 0, '0, '0)};
    rows = {rows, mk_row(cstrip_pkg::CHR_BSL, 1'b0, 0, 0, '0, '0)};
    rows = {rows, mk_row(cstrip_pkg::CHR_NL, 1'b0, 0, 0, '0, '0)};
    rows = {rows, mk_row(cstrip_pkg::CHR_SQ, 1'b0, 0, 0, '0, '0)};
    // line comment up to the newline
    rows = {rows, mk_row(cstrip_pkg::CHR_BSL, 1'b0, 0, 0, '0, '0)};
    rows = {rows, mk_row(8'h78, 1'b0, 0, 0, '0, '0)};
    rows = {rows, mk_row(cstrip_pkg::CHR_COLON, 1'b0, 0, 0, '0, '0)};
    rows = {rows, mk_row(cstrip_pkg::CHR_NL, 1'b0, 0, 0, '0, '0)};
    rows = {rows, mk_row(cstrip_pkg::CHR_BSL, 1'b0, 0, 0, '0, '0)};
    // marker completed by the final byte
    rows = {rows, mk_row(cstrip_pkg::CHR_COLON, 1'b1, 1, 2,
                         cstrip_pkg::out_beat_t'{cstrip_pkg::CHR_SP, 1'b0},
                         cstrip_pkg::out_beat_t'{cstrip_pkg::CHR_SP, 1'b1})};
    rows = {rows, mk_row(8'hFF, 1'b1, 1, 1, cstrip_pkg::out_beat_t'{8'hFF, 1'b1}, '0)};
    rows = {rows, mk_row(cstrip_pkg::CHR_BSL, 1'b1, 1, 1,
                         cstrip_pkg::out_beat_t'{cstrip_pkg::CHR_SP, 1'b1}, '0)};
    foreach (rows[i]) send_beat(rows[i]);

    sent = 0;
    while (sent < RAND_ITEMS) begin
      flen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      for (int k = 0; k < flen; k++) begin
        if (sent == DRAIN_AT) begin
          @(negedge clk) in_valid = 1'b0;
          while (strip_q.size() != 0) @(posedge clk);
        end
        calm = (sent >= CALM_FROM);
        send_beat(mk_row(pick_char(), k == flen - 1, 0, 0, '0, '0));
        sent++;
      end
    end

    @(negedge clk) in_valid = 1'b0;
    while (strip_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("comment_stripper_test: PASS");
    end else begin
      $display("comment_stripper_test: FAIL");
    end
    $finish;
  end

endmodule
